// ----- rtl/core/key_value_text_tokenizer_top_defines.svh -----
// Assertion macros shared by the tokenizer checker.
`ifndef KEY_VALUE_TEXT_TOKENIZER_TOP_DEFINES_SVH
`define KEY_VALUE_TEXT_TOKENIZER_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define KVT_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define KVT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/kvt_pkg.sv -----
// Package with token kinds and the token record of the key/value text tokenizer.
package kvt_pkg;

  localparam int FIELD_BITS = 16;
  localparam int KIND_BITS  = 4;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_LCURLY  = 4'd0,
    KIND_RCURLY  = 4'd1,
    KIND_EQUAL   = 4'd2,
    KIND_STRING  = 4'd3,
    KIND_INTEGER = 4'd4,
    KIND_REAL    = 4'd5,
    KIND_IDENT   = 4'd6,
    KIND_TRUE    = 4'd7,
    KIND_FALSE   = 4'd8,
    KIND_EOF     = 4'd9,
    KIND_UNKNOWN = 4'd10,
    KIND_UNTERM  = 4'd11,
    KIND_BADNUM  = 4'd12
  } token_kind_t;

  typedef struct packed {
    token_kind_t           kind;
    logic [FIELD_BITS-1:0] line;
    logic [FIELD_BITS-1:0] length;
    logic [FIELD_BITS-1:0] start;
  } token_t;

endpackage

// ----- rtl/core/key_value_text_tokenizer_top.sv -----
// Top level of the key/value text tokenizer: scanner state and result buffer.
//
// The tokenizer takes one source byte (or the end marker) per cycle, unless the input is
// held off, and turns it into zero to three tokens. The scanner state updates in the cycle a
// byte is accepted and the tokens that byte completes are written to a three-entry result
// buffer, which drains one token per cycle while the output is ready. While the output is
// ready, a byte that completes at most one token therefore does not hold the input; a byte
// that completes two or three tokens (a word or number ended directly by a bracket, an
// equals sign or an unknown byte, a number whose dot has no digit after it, or the end
// marker after a pending token) holds the input while the buffer drains. A new byte is
// taken while the last buffered token is being delivered. After the end marker all scanner
// state returns to its reset values and the next byte starts a new source.
module key_value_text_tokenizer_top #(
  parameter int POSITION_BITS = 16,
  parameter int LINE_BITS     = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // byte_req
  input  logic [0:0]  s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // token_start, token_length, line_number
  output logic [3:0]  m_axis_tuser,   // token_kind
  output logic        m_axis_tlast
);

  localparam logic [7:0] CH_LCURLY = 8'h7B;
  localparam logic [7:0] CH_RCURLY = 8'h7D;
  localparam logic [7:0] CH_EQUAL  = 8'h3D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  typedef enum logic [5:0] {
    MODE_IDLE   = 6'b000001,
    MODE_STRING = 6'b000010,
    MODE_IDENT  = 6'b000100,
    MODE_NUMBER = 6'b001000,
    MODE_NUMDOT = 6'b010000,
    MODE_REAL   = 6'b100000
  } mode_t;

  typedef logic [kvt_pkg::FIELD_BITS-1:0] field_t;

  mode_t                  scan_mode, scan_mode_next;
  logic [POSITION_BITS-1:0] byte_position, byte_position_next;
  logic [POSITION_BITS-1:0] token_begin, token_begin_next;
  logic [POSITION_BITS-1:0] dot_at, dot_at_next;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic [2:0]             ident_chars_seen, ident_chars_seen_next;
  logic [1:0]             keyword_match_flags, keyword_match_flags_next;

  kvt_pkg::token_t        result_slot [3];
  logic [1:0]             result_count;

  kvt_pkg::token_t        tok_list [3];
  logic [1:0]             tok_count;

  logic       is_end, accept, take;
  logic       is_digit, is_alpha, rescan;
  logic [7:0] c;
  logic [LINE_BITS-1:0] line_inc;
  field_t     at16, line16, str_start16, str_len16, num_len16, dot16, bad_len16;
  kvt_pkg::token_t ident_tok;

  function automatic field_t pos16(input logic [POSITION_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return w[kvt_pkg::FIELD_BITS-1:0];
  endfunction

  function automatic field_t diff16(input logic [POSITION_BITS-1:0] a,
                                    input logic [POSITION_BITS-1:0] b,
                                    input logic                     minus_one);
    logic [31:0] w;
    w = 32'(a) - 32'(b) - 32'(minus_one);
    return w[kvt_pkg::FIELD_BITS-1:0];
  endfunction

  function automatic logic true_ok(input logic [2:0] i, input logic [7:0] ch);
    logic ok;
    case (i)
      3'd0:    ok = (ch == "t");
      3'd1:    ok = (ch == "r");
      3'd2:    ok = (ch == "u");
      3'd3:    ok = (ch == "e");
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic logic false_ok(input logic [2:0] i, input logic [7:0] ch);
    logic ok;
    case (i)
      3'd0:    ok = (ch == "f");
      3'd1:    ok = (ch == "a");
      3'd2:    ok = (ch == "l");
      3'd3:    ok = (ch == "s");
      3'd4:    ok = (ch == "e");
      default: ok = 1'b0;
    endcase
    return ok;
  endfunction

  function automatic kvt_pkg::token_t make_tok(input kvt_pkg::token_kind_t kind,
                                               input field_t start,
                                               input field_t length,
                                               input field_t line);
    kvt_pkg::token_t t;
    t.kind   = kind;
    t.start  = start;
    t.length = length;
    t.line   = line;
    return t;
  endfunction

  assign c        = s_axis_tdata;
  assign is_end   = s_axis_tuser[0];
  assign take     = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (result_count == 2'd0) || ((result_count == 2'd1) && m_axis_tready);
  assign accept   = s_axis_tvalid && s_axis_tready;

  assign is_digit = (c >= "0") && (c <= "9");
  assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) ||
                    (c == CH_UNDER);

  assign line_inc = (line_count != '1) ? line_count + 1'b1 : line_count;

  always_comb begin
    logic [31:0] lw;
    lw          = 32'(line_count);
    line16      = lw[kvt_pkg::FIELD_BITS-1:0];
    at16        = pos16(byte_position);
    dot16       = pos16(dot_at);
    str_start16 = pos16(token_begin) + 1'b1;
    str_len16   = diff16(byte_position, token_begin, 1'b1);
    num_len16   = diff16(byte_position, token_begin, 1'b0);
    bad_len16   = diff16(dot_at, token_begin, 1'b0);
  end

  always_comb begin
    if (keyword_match_flags[0] && (ident_chars_seen == 3'd4)) begin
      ident_tok = make_tok(kvt_pkg::KIND_TRUE, pos16(token_begin), '0, line16);
    end else if (keyword_match_flags[1] && (ident_chars_seen == 3'd5)) begin
      ident_tok = make_tok(kvt_pkg::KIND_FALSE, pos16(token_begin), '0, line16);
    end else begin
      ident_tok = make_tok(kvt_pkg::KIND_IDENT, pos16(token_begin), num_len16, line16);
    end
  end

  always_comb begin
    tok_list[0] = '0;
    tok_list[1] = '0;
    tok_list[2] = '0;
    tok_count   = 2'd0;
    rescan      = 1'b0;
    scan_mode_next           = scan_mode;
    byte_position_next       = (byte_position != '1) ? byte_position + 1'b1 : byte_position;
    token_begin_next         = token_begin;
    dot_at_next              = dot_at;
    line_count_next          = line_count;
    ident_chars_seen_next    = ident_chars_seen;
    keyword_match_flags_next = keyword_match_flags;

    if (is_end) begin
      case (scan_mode)
        MODE_STRING: begin
          tok_list[tok_count] = make_tok(kvt_pkg::KIND_UNTERM, str_start16, str_len16, line16);
          tok_count = tok_count + 2'd1;
        end
        MODE_IDENT: begin
          tok_list[tok_count] = ident_tok;
          tok_count = tok_count + 2'd1;
        end
        MODE_NUMBER: begin
          tok_list[tok_count] = make_tok(kvt_pkg::KIND_INTEGER, pos16(token_begin),
                                         num_len16, line16);
          tok_count = tok_count + 2'd1;
        end
        MODE_NUMDOT: begin
          tok_list[tok_count] = make_tok(kvt_pkg::KIND_BADNUM, pos16(token_begin),
                                         bad_len16, line16);
          tok_count = tok_count + 2'd1;
          tok_list[tok_count] = make_tok(kvt_pkg::KIND_UNKNOWN, dot16, 16'd1, line16);
          tok_count = tok_count + 2'd1;
        end
        MODE_REAL: begin
          tok_list[tok_count] = make_tok(kvt_pkg::KIND_REAL, pos16(token_begin),
                                         num_len16, line16);
          tok_count = tok_count + 2'd1;
        end
        default: begin
        end
      endcase
      tok_list[tok_count] = make_tok(kvt_pkg::KIND_EOF, at16, '0, line16);
      tok_count = tok_count + 2'd1;
      scan_mode_next           = MODE_IDLE;
      byte_position_next       = '0;
      token_begin_next         = '0;
      dot_at_next              = '0;
      line_count_next          = LINE_BITS'(1);
      ident_chars_seen_next    = 3'd0;
      keyword_match_flags_next = 2'b11;
    end else begin
      case (scan_mode)
        MODE_STRING: begin
          if (c == CH_QUOTE) begin
            tok_list[tok_count] = make_tok(kvt_pkg::KIND_STRING, str_start16, str_len16,
                                           line16);
            tok_count = tok_count + 2'd1;
            scan_mode_next = MODE_IDLE;
          end else if (c == CH_NL) begin
            line_count_next = line_inc;
          end
        end
        MODE_IDENT: begin
          if (is_alpha || is_digit) begin
            keyword_match_flags_next = keyword_match_flags &
              {false_ok(ident_chars_seen, c), true_ok(ident_chars_seen, c)};
            ident_chars_seen_next = (ident_chars_seen != 3'd7) ? ident_chars_seen + 3'd1
                                                                : ident_chars_seen;
          end else begin
            tok_list[tok_count] = ident_tok;
            tok_count = tok_count + 2'd1;
            rescan = 1'b1;
          end
        end
        MODE_NUMBER: begin
          if (is_digit) begin
          end else if (c == CH_DOT) begin
            dot_at_next    = byte_position;
            scan_mode_next = MODE_NUMDOT;
          end else begin
            tok_list[tok_count] = make_tok(kvt_pkg::KIND_INTEGER, pos16(token_begin),
                                           num_len16, line16);
            tok_count = tok_count + 2'd1;
            rescan = 1'b1;
          end
        end
        MODE_NUMDOT: begin
          if (is_digit) begin
            scan_mode_next = MODE_REAL;
          end else begin
            tok_list[tok_count] = make_tok(kvt_pkg::KIND_BADNUM, pos16(token_begin),
                                           bad_len16, line16);
            tok_count = tok_count + 2'd1;
            tok_list[tok_count] = make_tok(kvt_pkg::KIND_UNKNOWN, dot16, 16'd1, line16);
            tok_count = tok_count + 2'd1;
            rescan = 1'b1;
          end
        end
        MODE_REAL: begin
          if (!is_digit) begin
            tok_list[tok_count] = make_tok(kvt_pkg::KIND_REAL, pos16(token_begin),
                                           num_len16, line16);
            tok_count = tok_count + 2'd1;
            rescan = 1'b1;
          end
        end
        default: begin
          rescan = 1'b1;
        end
      endcase

      if (rescan) begin
        scan_mode_next   = MODE_IDLE;
        token_begin_next = byte_position;
        case (c)
          CH_LCURLY: begin
            tok_list[tok_count] = make_tok(kvt_pkg::KIND_LCURLY, at16, '0, line16);
            tok_count = tok_count + 2'd1;
          end
          CH_RCURLY: begin
            tok_list[tok_count] = make_tok(kvt_pkg::KIND_RCURLY, at16, '0, line16);
            tok_count = tok_count + 2'd1;
          end
          CH_EQUAL: begin
            tok_list[tok_count] = make_tok(kvt_pkg::KIND_EQUAL, at16, '0, line16);
            tok_count = tok_count + 2'd1;
          end
          CH_QUOTE: begin
            scan_mode_next = MODE_STRING;
          end
          CH_SPACE, CH_TAB, CH_CR: begin
          end
          CH_NL: begin
            line_count_next = line_inc;
          end
          default: begin
            if (is_digit) begin
              scan_mode_next = MODE_NUMBER;
            end else if (is_alpha) begin
              scan_mode_next           = MODE_IDENT;
              ident_chars_seen_next    = 3'd1;
              keyword_match_flags_next = {false_ok(3'd0, c), true_ok(3'd0, c)};
            end else begin
              tok_list[tok_count] = make_tok(kvt_pkg::KIND_UNKNOWN, at16, 16'd1, line16);
              tok_count = tok_count + 2'd1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode           <= MODE_IDLE;
      byte_position       <= '0;
      token_begin         <= '0;
      dot_at              <= '0;
      line_count          <= LINE_BITS'(1);
      ident_chars_seen    <= 3'd0;
      keyword_match_flags <= 2'b11;
      result_count        <= 2'd0;
    end else if (accept) begin
      scan_mode           <= scan_mode_next;
      byte_position       <= byte_position_next;
      token_begin         <= token_begin_next;
      dot_at              <= dot_at_next;
      line_count          <= line_count_next;
      ident_chars_seen    <= ident_chars_seen_next;
      keyword_match_flags <= keyword_match_flags_next;
      result_count        <= tok_count;
    end else if (take) begin
      result_count        <= result_count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      result_slot[0] <= tok_list[0];
      result_slot[1] <= tok_list[1];
      result_slot[2] <= tok_list[2];
    end else if (take) begin
      result_slot[0] <= result_slot[1];
      result_slot[1] <= result_slot[2];
    end
  end

  assign m_axis_tvalid = (result_count != 2'd0);
  assign m_axis_tlast  = (result_count == 2'd1);
  assign m_axis_tuser  = result_slot[0].kind;
  assign m_axis_tdata  = {result_slot[0].line, result_slot[0].length, result_slot[0].start};

endmodule

// ----- rtl/core/kvt_checker.sv -----
// Port checker for the key/value text tokenizer, bound to the top level.
`include "key_value_text_tokenizer_top_defines.svh"

module kvt_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic [0:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [3:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  logic stalled, zero_len_kind, in_idle;

  assign stalled = m_axis_tvalid && !m_axis_tready;
  assign in_idle = s_axis_tvalid && !s_axis_tready && (s_axis_tdata == s_axis_tdata) &&
                   (s_axis_tuser == s_axis_tuser);
  assign zero_len_kind = (m_axis_tuser == kvt_pkg::KIND_LCURLY) ||
                         (m_axis_tuser == kvt_pkg::KIND_RCURLY) ||
                         (m_axis_tuser == kvt_pkg::KIND_EQUAL) ||
                         (m_axis_tuser == kvt_pkg::KIND_TRUE) ||
                         (m_axis_tuser == kvt_pkg::KIND_FALSE) ||
                         (m_axis_tuser == kvt_pkg::KIND_EOF);

  `KVT_ASSERT_NEXT(a_out_hold, stalled, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "Output item changed while stalled")
  `KVT_ASSERT_SAME(a_kind_range, m_axis_tvalid, m_axis_tuser <= kvt_pkg::KIND_BADNUM, "Token kind out of range")
  `KVT_ASSERT_SAME(a_eof_last, m_axis_tvalid && (m_axis_tuser == kvt_pkg::KIND_EOF), m_axis_tlast, "End-of-file token not marked last")
  `KVT_ASSERT_SAME(a_zero_len, m_axis_tvalid && zero_len_kind, m_axis_tdata[31:16] == 16'd0, "Fixed token with nonzero length")
  `KVT_ASSERT_SAME(a_ready_busy, in_idle, m_axis_tvalid, "Input held off while no item is pending")

endmodule

bind key_value_text_tokenizer_top kvt_checker u_kvt_checker (.*);
